// File: rtl/ric_pkg.sv
`timescale 1ns / 1ps
package ric_pkg;

    localparam int RIC_COEF_BITS = 21;
    localparam int RIC_PT_BITS = 32;
    localparam int RIC_KEY_BITS = 16;
    localparam int RIC_PIX_BITS = 20;
    localparam int RIC_QB = RIC_PIX_BITS + 1;
    localparam int RIC_COL_BITS = 63;
    localparam int RIC_THR_BITS = 16;
    localparam int RIC_ADDR_BITS = 6;
    localparam int RIC_DATA_BITS = 64;
    localparam logic signed [RIC_PIX_BITS-1:0] RIC_PIX_MAX = {1'b0, {(RIC_PIX_BITS-1){1'b1}}};
    localparam logic signed [RIC_PIX_BITS-1:0] RIC_PIX_MIN = {1'b1, {(RIC_PIX_BITS-1){1'b0}}};

    localparam logic [2:0] RIC_REG_COL0 = 3'd0;
    localparam logic [2:0] RIC_REG_COL1 = 3'd1;
    localparam logic [2:0] RIC_REG_COL2 = 3'd2;
    localparam logic [2:0] RIC_REG_COL3 = 3'd3;
    localparam logic [2:0] RIC_REG_THR = 3'd4;
    localparam logic [RIC_THR_BITS-1:0] RIC_THR_RESET = 16'd32;

    typedef struct packed {
        logic vld;
        logic zd;
        logic neg_u;
        logic neg_v;
        logic [RIC_KEY_BITS-1:0] key_u;
        logic [RIC_KEY_BITS-1:0] key_v;
    } ric_ctl_t;

endpackage

// File: rtl/ric_if.sv
`timescale 1ns / 1ps
interface ric_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0] key_u;
    logic [15:0] key_v;

    modport source (output valid, point_x, point_y, point_z, key_u, key_v, input ready);
    modport sink (input valid, point_x, point_y, point_z, key_u, key_v, output ready);
endinterface

interface ric_out_if;
    logic valid;
    logic ready;
    logic signed [19:0] proj_u;
    logic signed [19:0] proj_v;
    logic inlier;
    logic zero_depth;

    modport source (output valid, proj_u, proj_v, inlier, zero_depth, input ready);
    modport sink (input valid, proj_u, proj_v, inlier, zero_depth, output ready);
endinterface

// File: rtl/reprojection_inlier_check_core.sv
`timescale 1ns / 1ps
// Reprojection inlier check. Each beat on the points channel carries one world
// point in Q16.16 and its observed keypoint in Q12.4. The point goes through the
// 3x4 projection matrix held in the configuration registers, is divided by its
// depth, rounded to Q.4 and saturated, and is compared with the keypoint.
// Each point yields exactly one beat on the results channel with the projected
// pixel, the inlier flag and the zero depth flag.
// The matrix columns and the error threshold are written over the APB port at
// byte addresses 0, 8, 16, 24 and 32; the user must write them only while no
// points are in flight, as the block itself does not enforce it.
// A point is accepted every cycle unless the receiver stalls. It passes through
// the matrix products and sums, the restoring divider, which resolves one
// quotient bit per stage, and saturation, squared distance, threshold compare.
// When the receiver stalls the whole pipeline holds, and the points channel
// drops ready in the same cycle, so nothing is lost or repeated.
// Reset empties the pipeline, clears the matrix and sets the threshold to two
// pixels.
module reprojection_inlier_check_core #(
    parameter int COEF_BITS = ric_pkg::RIC_COEF_BITS
) (
    input  logic clk,
    input  logic rst_n,
    ric_in_if.sink points,
    ric_out_if.source results,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [ric_pkg::RIC_ADDR_BITS-1:0] paddr,
    input  logic [ric_pkg::RIC_DATA_BITS-1:0] pwdata,
    output logic [ric_pkg::RIC_DATA_BITS-1:0] prdata,
    output logic pready
);
    import ric_pkg::*;

    localparam int HW = COEF_BITS + 34;

    logic [RIC_COL_BITS-1:0] col [4];
    logic [RIC_THR_BITS-1:0] thr;
    logic adv;
    ric_ctl_t in_ctl, tr_ctl, dv_ctl;
    logic [HW-1:0] nu, nv, d;
    logic [RIC_QB-1:0] qu, qv;
    logic ovf_u, ovf_v;

    assign adv = !results.valid || results.ready;
    assign points.ready = adv;

    always_comb
    begin
        in_ctl = '0;
        in_ctl.vld = points.valid;
        in_ctl.key_u = points.key_u;
        in_ctl.key_v = points.key_v;
    end

    ric_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .col(col), .thr(thr)
    );

    ric_transform #(.COEF_BITS(COEF_BITS), .HW(HW)) u_tr (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_ctl(in_ctl),
        .px(points.point_x), .py(points.point_y), .pz(points.point_z), .col(col),
        .out_ctl(tr_ctl), .nu(nu), .nv(nv), .d(d)
    );

    ric_divider #(.HW(HW)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_ctl(tr_ctl),
        .nu(nu), .nv(nv), .d(d),
        .out_ctl(dv_ctl), .qu(qu), .qv(qv), .ovf_u(ovf_u), .ovf_v(ovf_v)
    );

    ric_check u_chk (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_ctl(dv_ctl),
        .qu(qu), .qv(qv), .ovf_u(ovf_u), .ovf_v(ovf_v), .thr(thr),
        .out_valid(results.valid), .proj_u(results.proj_u), .proj_v(results.proj_v),
        .inlier(results.inlier), .zero_depth(results.zero_depth)
    );
endmodule

// File: rtl/ric_cfg.sv
`timescale 1ns / 1ps
module ric_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [ric_pkg::RIC_ADDR_BITS-1:0] paddr,
    input  logic [ric_pkg::RIC_DATA_BITS-1:0] pwdata,
    output logic [ric_pkg::RIC_DATA_BITS-1:0] prdata,
    output logic pready,
    output logic [ric_pkg::RIC_COL_BITS-1:0] col [4],
    output logic [ric_pkg::RIC_THR_BITS-1:0] thr
);
    import ric_pkg::*;

    logic [RIC_COL_BITS-1:0] col_reg [4];
    logic [RIC_THR_BITS-1:0] thr_reg;
    logic [2:0] idx;
    logic wr;

    assign idx = paddr[5:3];
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                col_reg[c] <= '0;
            end
            thr_reg <= RIC_THR_RESET;
        end
        else if (wr)
        begin
            case (idx)
                RIC_REG_COL0: col_reg[0] <= pwdata[RIC_COL_BITS-1:0];
                RIC_REG_COL1: col_reg[1] <= pwdata[RIC_COL_BITS-1:0];
                RIC_REG_COL2: col_reg[2] <= pwdata[RIC_COL_BITS-1:0];
                RIC_REG_COL3: col_reg[3] <= pwdata[RIC_COL_BITS-1:0];
                RIC_REG_THR:  thr_reg <= pwdata[RIC_THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            RIC_REG_COL0: prdata = {1'b0, col_reg[0]};
            RIC_REG_COL1: prdata = {1'b0, col_reg[1]};
            RIC_REG_COL2: prdata = {1'b0, col_reg[2]};
            RIC_REG_COL3: prdata = {1'b0, col_reg[3]};
            RIC_REG_THR:  prdata = {{(RIC_DATA_BITS-RIC_THR_BITS){1'b0}}, thr_reg};
            default:      prdata = '0;
        endcase
    end

    assign col = col_reg;
    assign thr = thr_reg;
endmodule

// File: rtl/ric_transform.sv
`timescale 1ns / 1ps
module ric_transform #(
    parameter int COEF_BITS = ric_pkg::RIC_COEF_BITS,
    parameter int HW = COEF_BITS + 34
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  ric_pkg::ric_ctl_t in_ctl,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic [ric_pkg::RIC_COL_BITS-1:0] col [4],
    output ric_pkg::ric_ctl_t out_ctl,
    output logic [HW-1:0] nu,
    output logic [HW-1:0] nv,
    output logic [HW-1:0] d
);
    import ric_pkg::*;

    localparam int PW = COEF_BITS + 32;

    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [COEF_BITS-1:0] tc_reg [3];
    logic signed [HW-1:0] h_reg [3];
    ric_ctl_t c1_reg, c2_reg, c3_reg;
    ric_ctl_t c3_next;
    logic [HW-1:0] nu_reg, nv_reg, d_reg;
    logic signed [PW-1:0] pt [3];
    logic signed [HW-1:0] h_next [3];
    logic [HW-1:0] a0, a1, a2;

    assign pt[0] = PW'(px);
    assign pt[1] = PW'(py);
    assign pt[2] = PW'(pz);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            h_next[r] = HW'(prod_reg[r][0]) + HW'(prod_reg[r][1]) + HW'(prod_reg[r][2])
                      + (HW'(tc_reg[r]) <<< 16);
        end
    end

    assign a0 = h_reg[0][HW-1] ? HW'(-h_reg[0]) : HW'(h_reg[0]);
    assign a1 = h_reg[1][HW-1] ? HW'(-h_reg[1]) : HW'(h_reg[1]);
    assign a2 = h_reg[2][HW-1] ? HW'(-h_reg[2]) : HW'(h_reg[2]);

    always_comb
    begin
        c3_next = c2_reg;
        c3_next.zd = (h_reg[2] == '0);
        c3_next.neg_u = h_reg[0][HW-1] ^ h_reg[2][HW-1];
        c3_next.neg_v = h_reg[1][HW-1] ^ h_reg[2][HW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg.vld <= 1'b0;
            c2_reg.vld <= 1'b0;
            c3_reg.vld <= 1'b0;
        end
        else if (adv)
        begin
            c1_reg <= in_ctl;
            c2_reg <= c1_reg;
            c3_reg <= c3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= PW'($signed(col[c][COEF_BITS*r +: COEF_BITS])) * pt[c];
                end
                tc_reg[r] <= $signed(col[3][COEF_BITS*r +: COEF_BITS]);
                h_reg[r] <= h_next[r];
            end
            nu_reg <= a0;
            nv_reg <= a1;
            d_reg <= a2;
        end
    end

    assign out_ctl = c3_reg;
    assign nu = nu_reg;
    assign nv = nv_reg;
    assign d = d_reg;
endmodule

// File: rtl/ric_divider.sv
`timescale 1ns / 1ps
module ric_divider #(
    parameter int HW = ric_pkg::RIC_COEF_BITS + 34
) (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  ric_pkg::ric_ctl_t in_ctl,
    input  logic [HW-1:0] nu,
    input  logic [HW-1:0] nv,
    input  logic [HW-1:0] d,
    output ric_pkg::ric_ctl_t out_ctl,
    output logic [ric_pkg::RIC_QB-1:0] qu,
    output logic [ric_pkg::RIC_QB-1:0] qv,
    output logic ovf_u,
    output logic ovf_v
);
    import ric_pkg::*;

    localparam int NW = HW + 6;
    localparam int DW = HW + 1;
    localparam int CW = DW + RIC_QB;

    ric_ctl_t ctl_reg [RIC_QB+1];
    logic [NW-1:0] rem_u_reg [RIC_QB+1];
    logic [NW-1:0] rem_v_reg [RIC_QB+1];
    logic [DW-1:0] den_reg [RIC_QB+1];
    logic [RIC_QB-1:0] q_u_reg [RIC_QB+1];
    logic [RIC_QB-1:0] q_v_reg [RIC_QB+1];
    logic ovf_u_reg [RIC_QB+1];
    logic ovf_v_reg [RIC_QB+1];
    logic [NW-1:0] num_u, num_v;
    logic [DW-1:0] den;

    assign num_u = {1'b0, nu, 5'b0} + NW'(d);
    assign num_v = {1'b0, nv, 5'b0} + NW'(d);
    assign den = {d, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0].vld <= 1'b0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_u_reg[0] <= num_u;
            rem_v_reg[0] <= num_v;
            den_reg[0] <= den;
            q_u_reg[0] <= '0;
            q_v_reg[0] <= '0;
            ovf_u_reg[0] <= CW'(num_u) >= (CW'(den) << RIC_QB);
            ovf_v_reg[0] <= CW'(num_v) >= (CW'(den) << RIC_QB);
        end
    end

    for (genvar k = 0; k < RIC_QB; k++)
    begin : g_stage
        localparam int BI = RIC_QB - 1 - k;
        logic [CW-1:0] dsh;
        logic ge_u, ge_v;

        assign dsh = CW'(den_reg[k]) << BI;
        assign ge_u = CW'(rem_u_reg[k]) >= dsh;
        assign ge_v = CW'(rem_v_reg[k]) >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1].vld <= 1'b0;
            end
            else if (adv)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_u_reg[k+1] <= ge_u ? NW'(CW'(rem_u_reg[k]) - dsh) : rem_u_reg[k];
                rem_v_reg[k+1] <= ge_v ? NW'(CW'(rem_v_reg[k]) - dsh) : rem_v_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_u_reg[k+1] <= q_u_reg[k] | (RIC_QB'(ge_u) << BI);
                q_v_reg[k+1] <= q_v_reg[k] | (RIC_QB'(ge_v) << BI);
                ovf_u_reg[k+1] <= ovf_u_reg[k];
                ovf_v_reg[k+1] <= ovf_v_reg[k];
            end
        end
    end

    assign out_ctl = ctl_reg[RIC_QB];
    assign qu = q_u_reg[RIC_QB];
    assign qv = q_v_reg[RIC_QB];
    assign ovf_u = ovf_u_reg[RIC_QB];
    assign ovf_v = ovf_v_reg[RIC_QB];
endmodule

// File: rtl/ric_check.sv
`timescale 1ns / 1ps
module ric_check (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  ric_pkg::ric_ctl_t in_ctl,
    input  logic [ric_pkg::RIC_QB-1:0] qu,
    input  logic [ric_pkg::RIC_QB-1:0] qv,
    input  logic ovf_u,
    input  logic ovf_v,
    input  logic [ric_pkg::RIC_THR_BITS-1:0] thr,
    output logic out_valid,
    output logic signed [ric_pkg::RIC_PIX_BITS-1:0] proj_u,
    output logic signed [ric_pkg::RIC_PIX_BITS-1:0] proj_v,
    output logic inlier,
    output logic zero_depth
);
    import ric_pkg::*;

    localparam int DFW = RIC_PIX_BITS + 2;
    localparam int SQW = 2 * DFW;
    localparam int TSW = 2 * RIC_THR_BITS;

    ric_ctl_t ca_reg, cb_reg;
    logic va_reg, vb_reg, vc_reg;
    logic signed [RIC_PIX_BITS-1:0] pu_a_reg, pv_a_reg, pu_b_reg, pv_b_reg;
    logic signed [DFW-1:0] du_reg, dv_reg;
    logic [SQW-1:0] su_reg, sv_reg;
    logic [TSW-1:0] tsq_reg;
    logic signed [RIC_PIX_BITS-1:0] pu_c_reg, pv_c_reg;
    logic inl_reg, zd_reg;
    logic signed [RIC_PIX_BITS-1:0] pu, pv;

    function automatic logic signed [RIC_PIX_BITS-1:0] sat(
        input logic [RIC_QB-1:0] q, input logic ovf, input logic neg, input logic zd);
        logic signed [RIC_PIX_BITS-1:0] r;
        begin
            if (zd)
                r = '0;
            else if (neg)
                r = (ovf || q > RIC_QB'({1'b1, {(RIC_PIX_BITS-1){1'b0}}}))
                    ? RIC_PIX_MIN : RIC_PIX_BITS'(-q);
            else
                r = (ovf || q > RIC_QB'(RIC_PIX_MAX)) ? RIC_PIX_MAX : RIC_PIX_BITS'(q);
            return r;
        end
    endfunction

    assign pu = sat(qu, ovf_u, in_ctl.neg_u, in_ctl.zd);
    assign pv = sat(qv, ovf_v, in_ctl.neg_v, in_ctl.zd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_ctl.vld;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ca_reg <= in_ctl;
            pu_a_reg <= pu;
            pv_a_reg <= pv;
            du_reg <= DFW'(pu) - DFW'({1'b0, in_ctl.key_u});
            dv_reg <= DFW'(pv) - DFW'({1'b0, in_ctl.key_v});
            cb_reg <= ca_reg;
            pu_b_reg <= pu_a_reg;
            pv_b_reg <= pv_a_reg;
            su_reg <= SQW'(du_reg * du_reg);
            sv_reg <= SQW'(dv_reg * dv_reg);
            tsq_reg <= TSW'(thr) * TSW'(thr);
            pu_c_reg <= pu_b_reg;
            pv_c_reg <= pv_b_reg;
            zd_reg <= cb_reg.zd;
            inl_reg <= !cb_reg.zd && ((SQW+1)'(su_reg) + (SQW+1)'(sv_reg) < (SQW+1)'(tsq_reg));
        end
    end

    assign out_valid = vc_reg;
    assign proj_u = pu_c_reg;
    assign proj_v = pv_c_reg;
    assign inlier = inl_reg;
    assign zero_depth = zd_reg;
endmodule
